### rtl/rdst_pkg.sv
// Shared types and constants for the row dependency set table.
// No dependencies; the top level and the testbench import this package, rdst_ram does not.
`default_nettype none

package rdst_pkg;

  localparam int unsigned ROWS_DEF  = 64;
  localparam int unsigned SLOTS_DEF = 16;

  localparam int unsigned ROW_W  = 6;
  localparam int unsigned SIZE_W = 6;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned POS_W  = 4;

  typedef enum logic [1:0] {
    OP_SET_SIZE = 2'd0,
    OP_INSERT   = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BAD_ROW   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ROW,
    S_SCAN,
    S_SLOT,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [ROW_W-1:0]   row;
    logic [SIZE_W-1:0]  requested_size;
    logic [COL_W-1:0]   column;
    logic [POS_W-1:0]   read_position;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [COL_W-1:0]   entry_column;
    logic               at_end;
  } result_t;

endpackage

`default_nettype wire

### rtl/rdst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.
`default_nettype none

module rdst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/row_dependency_set_table.sv
// Row dependency set table: top level with the sequencer, row state RAM and slot RAM.
// Depends on rdst_pkg and rdst_ram.
//
// Keeps ROWS rows of up to SLOTS distinct column indices each. Items are taken one at a
// time; the result turns valid in the same cycle in which the next item can be taken. A
// set_size, an out-of-range or unused operation, or a read of a position at or beyond the
// fill count needs only the row state read; a read that hits a stored entry then reads the
// slot RAM as well; an insert reads the row state, then streams the stored entries out of
// the slot RAM and compares them with the new column (the scan stops at a match). A
// finished result sits in an output register, and the next item is taken while it waits;
// a new result that finds the register still stalled waits for it to drain. After reset
// the block clears every row of the row state RAM and takes no item meanwhile.
`default_nettype none

module row_dependency_set_table #(
  parameter int unsigned ROWS  = rdst_pkg::ROWS_DEF,
  parameter int unsigned SLOTS = rdst_pkg::SLOTS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rdst_pkg::item_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output rdst_pkg::result_t     out_data_o
);

  import rdst_pkg::*;

  localparam int unsigned RW  = $clog2(ROWS);
  localparam int unsigned CW  = $clog2(SLOTS + 1);
  localparam int unsigned RMW = 2 * CW;
  localparam int unsigned SD  = ROWS * SLOTS;
  localparam int unsigned SAW = $clog2(SD);

  state_e            state_q, state_d;
  item_t             req_q, req_d;
  result_t           res_q, res_d;
  result_t           out_q, out_d;
  logic              out_valid_q, out_valid_d;
  logic [CW-1:0]     cap_q, cap_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic [CW-1:0]     k_q, k_d;
  logic [RW-1:0]     clr_q, clr_d;

  logic              row_we;
  logic [RW-1:0]     row_waddr;
  logic [RMW-1:0]    row_wdata;
  logic [RW-1:0]     row_raddr;
  logic [RMW-1:0]    row_rdata;
  logic              slot_we;
  logic [SAW-1:0]    slot_waddr;
  logic [COL_W-1:0]  slot_wdata;
  logic [SAW-1:0]    slot_raddr;
  logic [COL_W-1:0]  slot_rdata;

  logic [RW-1:0]     row_idx;
  logic              row_ok;
  logic [SAW-1:0]    slot_base;
  logic [CW-1:0]     rd_cap;
  logic [CW-1:0]     rd_fill;
  logic [CW-1:0]     cur_cap;
  logic [CW-1:0]     cur_fill;
  logic              pos_hit;
  logic              scan_match;
  logic              scan_last;
  logic              out_free;
  logic              in_xfer;

  assign row_idx    = RW'(req_q.row);
  assign row_ok     = 32'(req_q.row) < ROWS;
  assign slot_base  = SAW'(32'(row_idx) * SLOTS);
  assign rd_cap     = row_rdata[RMW-1:CW];
  assign rd_fill    = row_rdata[CW-1:0];
  assign cur_cap    = (state_q == S_ROW) ? rd_cap  : cap_q;
  assign cur_fill   = (state_q == S_ROW) ? rd_fill : fill_q;
  assign pos_hit    = 32'(req_q.read_position) < 32'(rd_fill);
  assign scan_match = slot_rdata == req_q.column;
  assign scan_last  = (k_q + CW'(1)) == fill_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  rdst_ram #(
    .WIDTH (RMW),
    .DEPTH (ROWS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  rdst_ram #(
    .WIDTH (COL_W),
    .DEPTH (SD)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_q == RW'(ROWS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_ROW;
      end
      S_ROW: begin
        state_d = S_RESP;
        if (row_ok) begin
          case (req_q.operation)
            OP_READ: begin
              if (pos_hit) state_d = S_SLOT;
            end
            OP_INSERT: begin
              if (rd_fill != '0) state_d = S_SCAN;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_match || scan_last) state_d = S_RESP;
      end
      S_SLOT: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_d       = req_q;
    res_d       = res_q;
    cap_d       = cap_q;
    fill_d      = fill_q;
    k_d         = k_q;
    clr_d       = clr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    row_we      = 1'b0;
    row_waddr   = row_idx;
    row_wdata   = '0;
    row_raddr   = RW'(in_data_i.row);
    slot_we     = 1'b0;
    slot_waddr  = slot_base + SAW'(cur_fill);
    slot_wdata  = req_q.column;
    slot_raddr  = slot_base;

    unique case (state_q)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_q;
        clr_d     = clr_q + RW'(1);
      end
      S_IDLE: begin
        if (in_valid_i) req_d = in_data_i;
      end
      S_ROW: begin
        res_d  = '0;
        cap_d  = rd_cap;
        fill_d = rd_fill;
        k_d    = '0;
        if (req_q.operation == OP_SET_SIZE || req_q.operation == OP_INSERT ||
            req_q.operation == OP_READ) begin
          if (!row_ok) begin
            res_d.status = ST_BAD_ROW;
            res_d.at_end = req_q.operation == OP_READ;
          end else begin
            case (req_q.operation)
              OP_SET_SIZE: begin
                if (32'(req_q.requested_size) > SLOTS) begin
                  res_d.status = ST_TOO_LARGE;
                end else begin
                  row_we    = 1'b1;
                  row_wdata = {CW'(req_q.requested_size), {CW{1'b0}}};
                end
              end
              OP_READ: begin
                slot_raddr = slot_base + SAW'(req_q.read_position);
                if (!pos_hit) res_d.at_end = 1'b1;
              end
              default: begin
                // insert into an empty row needs no scan
                if (rd_fill == '0) begin
                  if (cur_fill >= cur_cap) begin
                    res_d.status = ST_FULL;
                  end else begin
                    slot_we   = 1'b1;
                    row_we    = 1'b1;
                    row_wdata = {cur_cap, cur_fill + CW'(1)};
                  end
                end
              end
            endcase
          end
        end
      end
      S_SCAN: begin
        // slot data belongs to index k_q, the read for k_q+1 goes out now
        k_d        = k_q + CW'(1);
        slot_raddr = slot_base + SAW'(k_q + CW'(1));
        if (scan_match) begin
          res_d.status = ST_PRESENT;
        end else if (scan_last) begin
          if (cur_fill >= cur_cap) begin
            res_d.status = ST_FULL;
          end else begin
            slot_we   = 1'b1;
            row_we    = 1'b1;
            row_wdata = {cur_cap, cur_fill + CW'(1)};
          end
        end
      end
      S_SLOT: begin
        res_d.entry_column = slot_rdata;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: begin
        clr_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    res_q  <= res_d;
    out_q  <= out_d;
    cap_q  <= cap_d;
    fill_q <= fill_d;
    k_q    <= k_d;
  end

  // a result register drains or holds unless a new result is loaded
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_RESP |=> out_valid_q == $past(out_valid_q && out_stall_i))
    else $error("output valid changed without a result load");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> k_q < fill_q)
    else $error("scan index beyond fill count");

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROW |-> rd_fill <= rd_cap)
    else $error("row fill count above capacity");

  a_no_slot_write_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !slot_we && !in_xfer)
    else $error("slot write or transfer during clearing pass");

endmodule

`default_nettype wire

### test/row_dependency_set_table_tb.sv
// Testbench for row_dependency_set_table: directed corner cases, then random row sequences.
// Depends on rdst_pkg and the block's RTL; results are checked against an in-bench table model.
`default_nettype none

module row_dependency_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rdst_pkg::*;

  localparam int unsigned TABLE_ROWS   = ROWS_DEF;
  localparam int unsigned SLOT_COUNT   = SLOTS_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          TARGET_ITEMS = 1250;
  localparam int          IDLE_PCT     = 26;

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  item_t   in_data_i   = '0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  result_t out_data_o;

  // table model state
  logic [4:0]       cap_model  [TABLE_ROWS];
  logic [4:0]       fill_model [TABLE_ROWS];
  logic [COL_W-1:0] slot_model [TABLE_ROWS][SLOT_COUNT];

  result_t expected_results[$];
  int      mismatch_count = 0;
  int      items_sent     = 0;
  logic    quiet_mode     = 1'b0;

  row_dependency_set_table uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic result_t predict_result(input item_t it);
    result_t     res;
    logic [4:0]  fill;
    logic        found;
    int unsigned r;
    res        = '0;
    res.status = ST_OK;
    r          = 32'(it.row);
    if (logic'(it.operation == OP_UNUSED)) begin
      // ignored, everything zero
    end else if (r >= TABLE_ROWS) begin
      res.status = ST_BAD_ROW;
      if (it.operation == OP_READ) res.at_end = 1'b1;
    end else begin
      fill = fill_model[r];
      case (it.operation)
        OP_SET_SIZE: begin
          if (32'(it.requested_size) > SLOT_COUNT) begin
            res.status = ST_TOO_LARGE;
          end else begin
            cap_model[r]  = it.requested_size[4:0];
            fill_model[r] = '0;
          end
        end
        OP_INSERT: begin
          found = 1'b0;
          for (int k = 0; k < 32'(fill) && k < SLOT_COUNT; k++) begin
            if (slot_model[r][k] == it.column) found = 1'b1;
          end
          if (found) begin
            res.status = ST_PRESENT;
          end else if (fill >= cap_model[r] || 32'(fill) >= SLOT_COUNT) begin
            res.status = ST_FULL;
          end else begin
            slot_model[r][fill[3:0]] = it.column;
            fill_model[r]            = fill + 5'd1;
          end
        end
        OP_READ: begin
          if (5'(it.read_position) < fill)
            res.entry_column = slot_model[r][it.read_position];
          else res.at_end = 1'b1;
        end
        default: begin
        end
      endcase
    end
    return res;
  endfunction

  function automatic item_t build_item(input logic [1:0] op, input logic [5:0] rw,
                                       input logic [5:0] size, input logic [5:0] col,
                                       input logic [3:0] pos);
    item_t it;
    it.operation      = op_e'(op);
    it.row            = rw;
    it.requested_size = size;
    it.column         = col;
    it.read_position  = pos;
    return it;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    if (mismatch_count < 100)
      $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // one transfer on the input side; valid stays high if the next call has no gap
  task automatic send_item(input item_t it);
    @(negedge clk_i);
    while (!quiet_mode && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet_mode && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", int'(out_data_o.status), -1);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", int'(out_data_o.status), int'(want.status));
        if (out_data_o.entry_column !== want.entry_column)
          report_mismatch("entry_column", int'(out_data_o.entry_column),
                          int'(want.entry_column));
        if (out_data_o.at_end !== want.at_end)
          report_mismatch("at_end", int'(out_data_o.at_end), int'(want.at_end));
      end
    end
  end

  task automatic test_corner_cases();
    send_item(build_item(OP_READ, 6'd0, 6'd0, 6'd0, 4'd0));          // read before any set_size
    send_item(build_item(OP_INSERT, 6'd0, 6'd63, 6'd5, 4'd15));      // capacity zero: full
    send_item(build_item(OP_SET_SIZE, 6'd0, 6'd17, 6'd0, 4'd0));     // just above slots
    send_item(build_item(OP_SET_SIZE, 6'd0, 6'd63, 6'd63, 4'd15));   // largest size
    send_item(build_item(OP_SET_SIZE, 6'd63, 6'd16, 6'd0, 4'd0));
    send_item(build_item(OP_INSERT, 6'd63, 6'd0, 6'd63, 4'd0));
    send_item(build_item(OP_INSERT, 6'd63, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_INSERT, 6'd63, 6'd0, 6'd63, 4'd0));      // duplicate
    send_item(build_item(OP_READ, 6'd63, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_READ, 6'd63, 6'd63, 6'd63, 4'd1));
    send_item(build_item(OP_READ, 6'd63, 6'd0, 6'd0, 4'd2));         // at fill count
    send_item(build_item(OP_READ, 6'd63, 6'd0, 6'd0, 4'd15));
    send_item(build_item(OP_SET_SIZE, 6'd1, 6'd1, 6'd0, 4'd0));
    send_item(build_item(OP_INSERT, 6'd1, 6'd0, 6'd42, 4'd0));
    send_item(build_item(OP_INSERT, 6'd1, 6'd0, 6'd43, 4'd0));       // full
    send_item(build_item(OP_INSERT, 6'd1, 6'd0, 6'd42, 4'd0));       // present wins over full
    send_item(build_item(OP_READ, 6'd1, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_SET_SIZE, 6'd63, 6'd0, 6'd0, 4'd0));     // set_size empties the row
    send_item(build_item(OP_READ, 6'd63, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_UNUSED, 6'd63, 6'd63, 6'd63, 4'd15));
    send_item(build_item(OP_UNUSED, 6'd0, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_SET_SIZE, 6'd2, 6'd0, 6'd0, 4'd0));
    send_item(build_item(OP_INSERT, 6'd2, 6'd0, 6'd1, 4'd0));        // capacity set to zero
  endtask

  // usually a set_size, then inserts from a narrow column window mixed with reads
  task automatic run_row_sequence();
    logic [5:0] rw;
    logic [5:0] base;
    int         pick;
    int         n;
    rw   = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 3)
      send_item(build_item(OP_SET_SIZE, rw, 6'd16, 6'($urandom), 4'($urandom)));
    else if (pick <= 7)
      send_item(build_item(OP_SET_SIZE, rw, 6'($urandom_range(0, 16)), 6'($urandom),
                           4'($urandom)));
    else if (pick == 8)
      send_item(build_item(OP_SET_SIZE, rw, 6'($urandom_range(17, 63)), 6'($urandom),
                           4'($urandom)));
    base = 6'($urandom);
    n    = $urandom_range(0, 20);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7)
        send_item(build_item(OP_INSERT, rw, 6'($urandom), base + 6'($urandom_range(0, 19)),
                             4'($urandom)));
      else
        send_item(build_item(OP_READ, rw, 6'($urandom), 6'($urandom), 4'($urandom)));
    end
    repeat ($urandom_range(1, 4))
      send_item(build_item(OP_READ, rw, 6'($urandom), 6'($urandom), 4'($urandom)));
  endtask

  task automatic test_back_to_back();
    quiet_mode = 1'b1;
    repeat (8) run_row_sequence();
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_traffic();
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          send_item(build_item(2'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
                               4'($urandom)));
      end else begin
        run_row_sequence();
      end
    end
  endtask

  initial begin
    for (int r = 0; r < TABLE_ROWS; r++) begin
      cap_model[r]  = '0;
      fill_model[r] = '0;
      for (int s = 0; s < SLOT_COUNT; s++) slot_model[r][s] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_corner_cases();
    test_back_to_back();
    test_random_traffic();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SLOT_COUNT + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(4_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
rtl/rdst_pkg.sv
rtl/rdst_ram.sv
rtl/row_dependency_set_table.sv
test/row_dependency_set_table_tb.sv
